// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");

`endif

// File: design/swfp_pkg.sv
// Types and constants of the SWF header and frame-size parser.
package swfp_pkg;

    localparam logic [3:0] HDR_BYTES      = 4'd8;
    localparam logic [7:0] SIG_COMPRESSED = 8'h43;   // 'C'
    localparam int         TWIPS_PER_PX   = 20;
    // ceil(2^34 / 5): floor(m / 5) == (m * RECIP5) >> 34 for any 32-bit m
    localparam logic [31:0] RECIP5        = 32'hCCCC_CCCD;
    localparam int          RECIP5_SHIFT  = 34;

    // header byte positions
    localparam logic [3:0] POS_SIG  = 4'd0;
    localparam logic [3:0] POS_VER  = 4'd3;
    localparam logic [3:0] POS_LEN0 = 4'd4;
    localparam logic [3:0] POS_LEN1 = 4'd5;
    localparam logic [3:0] POS_LEN2 = 4'd6;
    localparam logic [3:0] POS_LEN3 = 4'd7;

    // rectangle field being parsed
    localparam logic [2:0] FIELD_WIDTH = 3'd0;
    localparam logic [2:0] FIELD_XMIN  = 3'd1;
    localparam logic [2:0] FIELD_XMAX  = 3'd2;
    localparam logic [2:0] FIELD_YMIN  = 3'd3;
    localparam logic [2:0] FIELD_YMAX  = 3'd4;
    localparam logic [2:0] FIELD_DONE  = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed {
        logic signed [27:0] width_px;
        logic signed [27:0] height_px;
        logic [7:0]         version_num;
        logic [31:0]        file_length;
        logic               compressed;
    } result_t;

endpackage

// File: design/swfp_in_stage.sv
// Input register: holds one byte transaction until the parser takes it.
module swfp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  swfp_pkg::in_item_t in_item,
    output logic               item_valid,
    output swfp_pkg::in_item_t item,
    input  logic               item_take
);

    logic               valid_reg;
    logic               valid_next;
    swfp_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: design/swfp_div20.sv
// Signed twip value to pixels: divide by 20, truncating toward zero.
module swfp_div20 (
    input  logic signed [31:0] value,
    output logic signed [27:0] px
);

    logic [31:0] mag;
    logic [29:0] quarter;
    logic [63:0] prod;
    logic [27:0] quot;

    always_comb
    begin
        mag     = value[31] ? (32'd0 - value) : value;
        quarter = mag[31:2];                          // |v| / 4
        prod    = {34'd0, quarter} * {32'd0, swfp_pkg::RECIP5};
        quot    = prod[swfp_pkg::RECIP5_SHIFT +: 28]; // / 5
        px      = value[31] ? (28'sd0 - $signed(quot)) : $signed(quot);
    end

endmodule

// File: design/swfp_parse.sv
// Header decode, bit-packed rectangle extraction and parser state.
module swfp_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  swfp_pkg::in_item_t item,
    input  logic               out_free,
    output logic               item_take,
    output logic               emit,
    output swfp_pkg::result_t  result
);

    localparam int LANES = 4;

    logic [3:0]         pos_reg,    pos_next;
    logic [39:0]        acc_reg,    acc_next;
    logic [5:0]         held_reg,   held_next;
    logic [4:0]         fw_reg,     fw_next;
    logic [2:0]         fn_reg,     fn_next;
    logic signed [27:0] min_reg,    min_next;
    logic signed [27:0] ws_reg,     ws_next;
    logic [7:0]         ver_reg,    ver_next;
    logic [31:0]        len_reg,    len_next;
    logic               comp_reg,   comp_next;
    logic               fin_reg,    fin_next;

    // state as seen by this byte (start of file clears it)
    logic [3:0]         cur_pos;
    logic [39:0]        cur_acc;
    logic [5:0]         cur_held;
    logic [4:0]         cur_fw;
    logic [2:0]         cur_fn;
    logic signed [27:0] cur_min;
    logic signed [27:0] cur_ws;
    logic [7:0]         cur_ver;
    logic [31:0]        cur_len;
    logic               cur_comp;
    logic               cur_fin;

    logic [39:0]        acc1;
    logic [5:0]         held1;
    logic [5:0]         held2;
    logic               take_w;
    logic [4:0]         w;
    logic [2:0]         fn_base;
    logic [31:0]        wmask;
    logic [39:0]        wshift;
    logic [6:0]         need   [LANES];
    logic               active [LANES];
    logic signed [31:0] sv     [LANES];
    logic signed [27:0] px     [LANES];
    logic signed [27:0] px0;

    function automatic logic signed [31:0] sext(input logic [31:0] raw, input logic [4:0] n);
        logic [31:0] mask;
        logic        sign;
        mask = (32'd1 << n) - 32'd1;
        sign = (n != 5'd0) && raw[n - 5'd1];
        return sign ? $signed(raw | ~mask) : $signed(raw);
    endfunction

    // narrow values only (field width of 7 or less)
    function automatic logic signed [27:0] div20_small(input logic signed [7:0] v);
        logic [7:0]  mag;
        logic [27:0] q;
        mag = v[7] ? (8'd0 - v) : v;
        if (mag >= 8'd60)
            q = 28'd3;
        else if (mag >= 8'd40)
            q = 28'd2;
        else if (mag >= 8'd20)
            q = 28'd1;
        else
            q = 28'd0;
        return v[7] ? (28'sd0 - $signed(q)) : $signed(q);
    endfunction

    swfp_div20 u_div20 (
        .value (sv[0]),
        .px    (px0)
    );

    always_comb
    begin
        if (item.start_of_file)
        begin
            cur_pos  = 4'd0;
            cur_acc  = 40'd0;
            cur_held = 6'd0;
            cur_fw   = 5'd0;
            cur_fn   = swfp_pkg::FIELD_WIDTH;
            cur_min  = 28'sd0;
            cur_ws   = 28'sd0;
            cur_ver  = 8'd0;
            cur_len  = 32'd0;
            cur_comp = 1'b0;
            cur_fin  = 1'b0;
        end
        else
        begin
            cur_pos  = pos_reg;
            cur_acc  = acc_reg;
            cur_held = held_reg;
            cur_fw   = fw_reg;
            cur_fn   = fn_reg;
            cur_min  = min_reg;
            cur_ws   = ws_reg;
            cur_ver  = ver_reg;
            cur_len  = len_reg;
            cur_comp = comp_reg;
            cur_fin  = fin_reg;
        end
    end

    // field extraction lanes: up to four values can complete on one byte
    always_comb
    begin
        acc1    = {cur_acc[31:0], item.data_byte};
        held1   = cur_held + 6'd8;
        take_w  = (cur_fn == swfp_pkg::FIELD_WIDTH) && (held1 >= 6'd5);
        wshift  = acc1 >> (held1 - 6'd5);
        w       = take_w ? wshift[4:0] : cur_fw;
        held2   = take_w ? (held1 - 6'd5) : held1;
        fn_base = take_w ? swfp_pkg::FIELD_XMIN : cur_fn;
        wmask   = (32'd1 << w) - 32'd1;
        for (int k = 0; k < LANES; k++)
        begin
            need[k]   = 7'(k + 1) * {2'd0, w};
            active[k] = (fn_base != swfp_pkg::FIELD_WIDTH)
                     && (({1'b0, fn_base} + 4'(k)) <= {1'b0, swfp_pkg::FIELD_YMAX})
                     && ({1'b0, held2} >= need[k]);
            sv[k]     = sext(32'(acc1 >> (held2 - need[k][5:0])) & wmask, w);
        end
        px[0] = px0;
        for (int k = 1; k < LANES; k++)
        begin
            px[k] = div20_small(sv[k][7:0]);
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        acc_next  = acc_reg;
        held_next = held_reg;
        fw_next   = fw_reg;
        fn_next   = fn_reg;
        min_next  = min_reg;
        ws_next   = ws_reg;
        ver_next  = ver_reg;
        len_next  = len_reg;
        comp_next = comp_reg;
        fin_next  = fin_reg;
        emit      = 1'b0;
        result.width_px  = 28'sd0;
        result.height_px = 28'sd0;
        if (!cur_fin)
        begin
            pos_next  = cur_pos;
            acc_next  = cur_acc;
            held_next = cur_held;
            fw_next   = cur_fw;
            fn_next   = cur_fn;
            min_next  = cur_min;
            ws_next   = cur_ws;
            ver_next  = cur_ver;
            len_next  = cur_len;
            comp_next = cur_comp;
            fin_next  = 1'b0;
            if (cur_pos < swfp_pkg::HDR_BYTES)
            begin
                case (cur_pos)
                    swfp_pkg::POS_SIG:  comp_next = (item.data_byte == swfp_pkg::SIG_COMPRESSED);
                    swfp_pkg::POS_VER:  ver_next  = item.data_byte;
                    swfp_pkg::POS_LEN0: len_next[7:0]   = item.data_byte;
                    swfp_pkg::POS_LEN1: len_next[15:8]  = item.data_byte;
                    swfp_pkg::POS_LEN2: len_next[23:16] = item.data_byte;
                    swfp_pkg::POS_LEN3: len_next[31:24] = item.data_byte;
                    default: ;
                endcase
                pos_next = cur_pos + 4'd1;
                if ((cur_pos == swfp_pkg::POS_LEN3) && cur_comp)
                begin
                    emit     = 1'b1;
                    fin_next = 1'b1;
                end
            end
            else
            begin
                fw_next   = w;
                fn_next   = fn_base;
                held_next = held2;
                for (int k = 0; k < LANES; k++)
                begin
                    if (active[k])
                    begin
                        held_next = held2 - need[k][5:0];
                        fn_next   = fn_base + 3'(k + 1);
                        case (fn_base + 3'(k))
                            swfp_pkg::FIELD_XMIN,
                            swfp_pkg::FIELD_YMIN: min_next = px[k];
                            swfp_pkg::FIELD_XMAX: ws_next  = px[k] - min_next;
                            swfp_pkg::FIELD_YMAX:
                            begin
                                result.height_px = px[k] - min_next;
                                emit             = 1'b1;
                                fin_next         = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                acc_next = acc1 & ((40'd1 << held_next) - 40'd1);
                result.width_px = ws_next;
            end
        end
        result.version_num = ver_next;
        result.file_length = len_next;
        result.compressed  = comp_next;
        if (comp_next)
        begin
            result.width_px  = 28'sd0;
            result.height_px = 28'sd0;
        end
    end

    assign item_take = item_valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 4'd0;
            acc_reg  <= 40'd0;
            held_reg <= 6'd0;
            fw_reg   <= 5'd0;
            fn_reg   <= swfp_pkg::FIELD_WIDTH;
            min_reg  <= 28'sd0;
            ws_reg   <= 28'sd0;
            ver_reg  <= 8'd0;
            len_reg  <= 32'd0;
            comp_reg <= 1'b0;
            fin_reg  <= 1'b1;
        end
        else if (item_take)
        begin
            pos_reg  <= pos_next;
            acc_reg  <= acc_next;
            held_reg <= held_next;
            fw_reg   <= fw_next;
            fn_reg   <= fn_next;
            min_reg  <= min_next;
            ws_reg   <= ws_next;
            ver_reg  <= ver_next;
            len_reg  <= len_next;
            comp_reg <= comp_next;
            fin_reg  <= fin_next;
        end
    end

endmodule

// File: design/swfp_out_stage.sv
// Result register: holds one result transaction until it is taken.
module swfp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  swfp_pkg::result_t load_result,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_ready,
    output swfp_pkg::result_t result
);

    logic              valid_reg;
    logic              valid_next;
    swfp_pkg::result_t result_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

endmodule

// File: design/swf_header_frame_size_parser.sv
// Top level of the SWF header and frame-size parser.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  in      | input     | in_valid / in_ready | data_byte, start_of_file
//  out     | output    | out_valid/out_ready | width_px, height_px, version_num,
//          |           |                     | file_length, compressed
//
// One byte transaction per cycle unless a completing byte waits on out; the parser
// state update (bit accumulator, field counter, one divide-by-20 multiplier) is
// combinational and registered on each taken byte. A completing byte passes the
// input register, then loads the result register and sets out_valid once out is free.
// After reset the block ignores bytes until one arrives with start_of_file set.
// Bytes with no result drain while out is stalled; a completing byte waits.
`include "assert_macros.svh"

module swf_header_frame_size_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               start_of_file,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [27:0] width_px,
    output logic signed [27:0] height_px,
    output logic [7:0]         version_num,
    output logic [31:0]        file_length,
    output logic               compressed
);

    swfp_pkg::in_item_t in_item;
    swfp_pkg::in_item_t item;
    swfp_pkg::result_t  parse_result;
    swfp_pkg::result_t  result;
    logic               item_valid;
    logic               item_take;
    logic               emit;
    logic               out_free;

    assign in_item.data_byte     = data_byte;
    assign in_item.start_of_file = start_of_file;

    // input register
    swfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // header decode and rectangle fields; state advances on item_take
    swfp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .item_take  (item_take),
        .emit       (emit),
        .result     (parse_result)
    );

    // result register, loaded only by a byte that completes a result
    swfp_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (item_take && emit),
        .load_result (parse_result),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result)
    );

    assign width_px    = result.width_px;
    assign height_px   = result.height_px;
    assign version_num = result.version_num;
    assign file_length = result.file_length;
    assign compressed  = result.compressed;

    // compressed files never report dimensions
    `ASSERT_IMPL(a_comp_zero_dims, clk, rst_n, out_valid && compressed, ~|(width_px | height_px))
    // a new result always comes from a byte held in the input register
    `ASSERT_IMPL(a_result_from_item, clk, rst_n, $rose(out_valid), $past(item_valid))
    // with the result register empty, a held byte is always consumed
    `ASSERT_IMPL(a_no_false_stall, clk, rst_n, item_valid && !out_valid, item_take && in_ready)

endmodule

// File: test/swf_header_frame_size_parser_test.sv
`timescale 1ns / 1ps
// Testbench of the SWF header and frame-size parser: directed bytes, then random files.

module swf_header_frame_size_parser_test;

    // one row of the directed stimulus; res is used only where typed is set
    typedef struct {
        logic [7:0]        data;
        logic              sof;
        bit                typed;
        swfp_pkg::result_t res;
    } dir_row_t;

    localparam int DIR_ROWS   = 22;
    localparam int RAND_BYTES = 1150;
    localparam int LONG_HOLD  = 400;   // cycles the receiver holds off when asked

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         data_byte = 8'h00;
    logic               start_of_file = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [27:0] width_px;
    logic signed [27:0] height_px;
    logic [7:0]         version_num;
    logic [31:0]        file_length;
    logic               compressed;

    swf_header_frame_size_parser DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .width_px      (width_px),
        .height_px     (height_px),
        .version_num   (version_num),
        .file_length   (file_length),
        .compressed    (compressed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // ------------------------------------------------------------------
    // Parser shadow state: a mirror of what the block holds after reset
    // ------------------------------------------------------------------
    logic [3:0]  hdr_pos   = '0;     // header byte index, parks at HDR_BYTES
    logic [63:0] acc       = '0;     // rectangle bits not yet consumed (40 used)
    int          held      = 0;      // valid bits in acc
    int          n_width   = 0;      // rectangle field width N
    logic [2:0]  field_idx = swfp_pkg::FIELD_WIDTH;
    int          min_px    = 0;      // xmin/20 or ymin/20 waiting for its partner
    int          width_keep = 0;
    logic [7:0]  ver       = '0;
    logic [31:0] len       = '0;
    bit          comp      = 1'b0;
    bit          idle      = 1'b1;   // out of reset the parser waits for a start

    swfp_pkg::result_t frame_sizes[$];   // frame sizes still owed by the block
    bit                typed_pending = 1'b0;
    swfp_pkg::result_t typed_res;
    bit                hold_req = 1'b0;
    bit                tx_burst = 1'b0;

    int errors         = 0;
    int sizes_checked  = 0;
    int bytes_accepted = 0;
    int files_sent     = 0;
    int file_bytes     = 0;
    int holds_done     = 0;

    dir_row_t dir_rows [DIR_ROWS];

    // take the n most significant held bits, MSB first
    function automatic logic [63:0] pull_bits(input int n);
        int          shift;
        logic [63:0] v;
        shift = held - n;
        v     = (acc >> shift) & ((64'd1 << n) - 64'd1);
        acc   = acc & ((64'd1 << shift) - 64'd1);
        held  = shift;
        return v;
    endfunction

    function automatic swfp_pkg::result_t pack_result(input int w, input int h);
        swfp_pkg::result_t r;
        r.width_px    = w[27:0];
        r.height_px   = h[27:0];
        r.version_num = ver;
        r.file_length = len;
        r.compressed  = comp;
        return r;
    endfunction

    // advance the shadow parser by one byte; returns 1 when a frame size completes
    function automatic bit parse_byte(input logic [7:0] b, input logic sof,
                                      output swfp_pkg::result_t r);
        logic [63:0] raw;
        longint      v;
        int          px;
        int          n;
        r = '0;
        if (sof)
        begin
            hdr_pos    = '0;
            acc        = '0;
            held       = 0;
            n_width    = 0;
            field_idx  = swfp_pkg::FIELD_WIDTH;
            min_px     = 0;
            width_keep = 0;
            ver        = '0;
            len        = '0;
            comp       = 1'b0;
            idle       = 1'b0;
        end
        if (idle)
            return 1'b0;

        // header bytes: signature, version, little-endian length
        if (hdr_pos < swfp_pkg::HDR_BYTES)
        begin
            case (hdr_pos)
                swfp_pkg::POS_SIG:  comp = (b == swfp_pkg::SIG_COMPRESSED);
                swfp_pkg::POS_VER:  ver = b;
                swfp_pkg::POS_LEN0: len[7:0] = b;
                swfp_pkg::POS_LEN1: len[15:8] = b;
                swfp_pkg::POS_LEN2: len[23:16] = b;
                swfp_pkg::POS_LEN3: len[31:24] = b;
                default: ;
            endcase
            hdr_pos = hdr_pos + 4'd1;
            if (hdr_pos == swfp_pkg::HDR_BYTES && comp)
            begin
                r    = pack_result(0, 0);
                idle = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end

        // rectangle: shift the byte in, then drain every complete field
        acc  = ((acc << 8) | 64'(b)) & 64'hFF_FFFF_FFFF;
        held = held + 8;
        if (field_idx == swfp_pkg::FIELD_WIDTH && held >= 5)
        begin
            n_width   = int'(pull_bits(5));
            field_idx = swfp_pkg::FIELD_XMIN;
        end
        while (field_idx >= swfp_pkg::FIELD_XMIN && field_idx <= swfp_pkg::FIELD_YMAX
               && held >= n_width)
        begin
            n   = n_width;
            raw = pull_bits(n);
            v   = longint'(raw);
            if (n > 0 && raw[n - 1])
                v = v - longint'(64'd1 << n);
            px = int'(v / swfp_pkg::TWIPS_PER_PX);     // truncates toward zero
            case (field_idx)
                swfp_pkg::FIELD_XMIN, swfp_pkg::FIELD_YMIN: min_px = px;
                swfp_pkg::FIELD_XMAX:                       width_keep = px - min_px;
                default:
                begin
                    r         = pack_result(width_keep, px - min_px);
                    field_idx = swfp_pkg::FIELD_DONE;
                    idle      = 1'b1;
                    return 1'b1;
                end
            endcase
            field_idx = field_idx + 3'd1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor. Everything is sampled at the falling edge, where inputs and
    // outputs are settled; a handshake seen here completes at the next
    // rising edge. Input prediction runs first so the queue order matches
    // the order of transactions.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : monitor
        swfp_pkg::result_t r;
        bit                got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                got = parse_byte(data_byte, start_of_file, r);
                bytes_accepted++;
                if (typed_pending)
                begin
                    // hand-written expectation wins over the shadow parser
                    frame_sizes.push_back(typed_res);
                    typed_pending = 1'b0;
                end
                else if (got)
                    frame_sizes.push_back(r);
            end
            if (out_valid && out_ready)
            begin
                if (frame_sizes.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %0d x %0d",
                             $time, width_px, height_px);
                end
                else
                begin
                    r = frame_sizes.pop_front();
                    check_field("width_px", r.width_px, width_px);
                    check_field("height_px", r.height_px, height_px);
                    check_field("version_num", r.version_num, version_num);
                    check_field("file_length", r.file_length, file_length);
                    check_field("compressed", r.compressed, compressed);
                    sizes_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side: one transaction per call, with a random lead-in gap
    // unless the current file runs as a burst.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic sof, input bit typed,
                             input swfp_pkg::result_t res);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        typed_pending = typed;
        typed_res     = res;
        in_valid      <= 1'b1;
        data_byte     <= b;
        start_of_file <= sof;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // one well-formed file; a cut > 0 below its size truncates it so the next start lands mid-file
    task automatic send_file(input bit zip, input int cut);
        logic [7:0]  img[$];
        bit          bits[$];
        logic [7:0]  b;
        logic [63:0] val;
        int          n;
        int          k;
        int          j;
        int          f;
        if (zip)
            b = swfp_pkg::SIG_COMPRESSED;
        else if ($urandom_range(0, 1) == 0)
            b = 8'h46;                        // 'F'
        else
        begin
            do
                b = 8'($urandom);
            while (b == swfp_pkg::SIG_COMPRESSED);
        end
        img.push_back(b);
        repeat (7) img.push_back(8'($urandom));   // rest of signature, version, length

        if (!zip)
        begin
            case ($urandom_range(0, 9))
                0:       n = 0;
                1:       n = 31;
                2:       n = 1;
                default: n = $urandom_range(1, 31);
            endcase
            for (j = 4; j >= 0; j--)
                bits.push_back(n[j]);
            if (n > 0)
            begin
                for (f = 0; f < 4; f++)
                begin
                    case ($urandom_range(0, 5))
                        0:       val = 64'd1 << (n - 1);           // most negative
                        1:       val = (64'd1 << (n - 1)) - 64'd1; // most positive
                        2:       val = '1;                         // minus one
                        3:       val = '0;
                        default: val = {$urandom, $urandom};
                    endcase
                    for (j = n - 1; j >= 0; j--)
                        bits.push_back(val[j]);
                end
            end
            while (bits.size() % 8 != 0)
                bits.push_back(1'($urandom_range(0, 1)));
            for (k = 0; k < bits.size(); k += 8)
            begin
                for (j = 0; j < 8; j++)
                    b[7 - j] = bits[k + j];
                img.push_back(b);
            end
        end

        if (cut > 0 && cut < img.size())
            img = img[0:cut - 1];
        foreach (img[i])
            send_byte(img[i], i == 0, 1'b0, '0);
        file_bytes += img.size();
        files_sent++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall per result, runs with no stall, and a long
    // hold-off on request so the block backs up into its input.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall;
        int run_left;
        run_left = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
            begin
                if (run_left > 0)
                begin
                    stall = 0;
                    run_left--;
                end
                else
                begin
                    stall = $urandom_range(0, 13);
                    if ($urandom_range(0, 5) == 0)
                        run_left = $urandom_range(4, 16);
                end
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid)
                @(negedge clk);
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int round;
        int sel;
        int cnt;
        dir_rows = '{
            '{8'hA5, 1'b0, 1'b0, '0},          // before any start: ignored
            // compressed file, header at its extremes
            '{swfp_pkg::SIG_COMPRESSED, 1'b1, 1'b0, '0},
            '{8'h57, 1'b0, 1'b0, '0},
            '{8'h53, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},          // version
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, '{28'sd0, 28'sd0, 8'hFF, 32'hFFFF_FFFF, 1'b1}},
            '{8'h5A, 1'b0, 1'b0, '0},          // after the result: ignored
            '{8'h46, 1'b1, 1'b0, '0},          // file abandoned after two bytes
            '{8'h57, 1'b0, 1'b0, '0},
            // start in mid-file, then a zero-width rectangle
            '{8'h46, 1'b1, 1'b0, '0},
            '{8'h57, 1'b0, 1'b0, '0},
            '{8'h53, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b1, '{28'sd0, 28'sd0, 8'h00, 32'h0000_0000, 1'b0}},
            '{8'hFF, 1'b0, 1'b0, '0}           // ignored again
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].sof, dir_rows[i].typed, dir_rows[i].res);

        round = 0;
        while (file_bytes < RAND_BYTES)
        begin
            round++;
            tx_burst = ($urandom_range(0, 3) == 0);
            if (round == 12 || round == 40)
                hold_req = 1'b1;
            if (round == 25 || round == 55)
            begin
                // drain: hold the input until every owed frame size is out
                in_valid <= 1'b0;
                @(posedge clk);
                while (frame_sizes.size() != 0)
                    @(posedge clk);
            end
            sel = $urandom_range(0, 9);
            case (sel)
                0:
                begin
                    // noise: a start followed by random bytes
                    cnt = $urandom_range(1, 20);
                    send_byte(8'($urandom), 1'b1, 1'b0, '0);
                    repeat (cnt - 1) send_byte(8'($urandom), 1'b0, 1'b0, '0);
                    file_bytes += cnt;
                end
                1:       send_file($urandom_range(0, 3) == 0, $urandom_range(1, 14));
                2:       send_file(1'b1, 0);
                default: send_file(1'b0, 0);
            endcase
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (frame_sizes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);   // results trail their byte through the input register; ample margin

        $display("Run covered %0d random files and %0d accepted bytes in all,", files_sent,
                 bytes_accepted);
        $display("with %0d frame sizes checked and %0d long output hold-offs.", sizes_checked,
                 holds_done);
        if (errors == 0 && frame_sizes.size() == 0)
            $display("** swf_header_frame_size_parser: PASSED **");
        else
            $display("** swf_header_frame_size_parser: FAILED **");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #3_000_000;
        $display("** swf_header_frame_size_parser: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/swfp_pkg.sv
design/swfp_in_stage.sv
design/swfp_div20.sv
design/swfp_parse.sv
design/swfp_out_stage.sv
design/swf_header_frame_size_parser.sv
test/swf_header_frame_size_parser_test.sv
